>>> rtl/xor_checked_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_assert.svh
// Assertion helper macros used by the frame receiver sequencer.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define XCFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xcfr same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define XCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xcfr next-cycle check failed");

`endif

>>> rtl/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Constants, types and helpers for the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

   localparam int BUF_SIZE = 64;
   localparam int ARG_SIZE = 32;

   localparam int BYTE_W = 8;
   localparam int IDX_W  = 6;                  // arg_index field width
   localparam int FILL_W = $clog2(BUF_SIZE);   // holds 0 .. BUF_SIZE-1
   localparam int ADDR_W = $clog2(BUF_SIZE);
   localparam int ARG_W  = $clog2(ARG_SIZE);   // holds 0 .. ARG_SIZE-1
   localparam int CMP_W  = 8;                  // room for lengths and ARG_SIZE-1

   localparam logic [BYTE_W-1:0] CH_START = 8'h23;  // '#'
   localparam logic [BYTE_W-1:0] CH_END   = 8'h0A;  // '\n'
   localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;  // '*'

   // Controller to datapath.
   typedef struct packed {
      logic take_byte;   // input beat accepted this cycle
      logic arg_read;    // fetch argument byte at current index
      logic arg_next;    // advance argument index
   } xcfr_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic frame_done;  // current input byte closes a good frame
      logic arg_last;    // current result is the last of the frame
   } xcfr_stat_type;

   // {valid, nibble} for one ASCII hex digit.
   function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h61 + 8'd10)};
      end
      return r;
   endfunction

endpackage

>>> rtl/xcfr_req_if.sv
// ----------------------------------------------------------------------------
// xcfr_req_if
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface xcfr_req_if;
   import xcfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/xcfr_rsp_if.sv
// ----------------------------------------------------------------------------
// xcfr_rsp_if
// Valid/ready channel carrying one decoded frame result per beat.
// ----------------------------------------------------------------------------
interface xcfr_rsp_if;
   import xcfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_addr;
   logic [BYTE_W-1:0] frame_cmd;
   logic              has_arg_byte;
   logic [BYTE_W-1:0] arg_byte;
   logic [IDX_W-1:0]  arg_index;
   logic              last_of_frame;

   modport source (output valid, output frame_addr, output frame_cmd,
                   output has_arg_byte, output arg_byte, output arg_index,
                   output last_of_frame, input ready);
   modport sink   (input valid, input frame_addr, input frame_cmd,
                   input has_arg_byte, input arg_byte, input arg_index,
                   input last_of_frame, output ready);
endinterface

>>> rtl/xcfr_dp.sv
// ----------------------------------------------------------------------------
// xcfr_dp
// Frame datapath: byte store, checksum and hex accumulation, argument drain.
// ----------------------------------------------------------------------------
module xcfr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [xcfr_pkg::BYTE_W-1:0]   rx_byte,
   input  xcfr_pkg::xcfr_cmd_type        cmd,
   output xcfr_pkg::xcfr_stat_type       stat,
   output logic [xcfr_pkg::BYTE_W-1:0]   frame_addr,
   output logic [xcfr_pkg::BYTE_W-1:0]   frame_cmd,
   output logic                          has_arg_byte,
   output logic [xcfr_pkg::BYTE_W-1:0]   arg_byte,
   output logic [xcfr_pkg::IDX_W-1:0]    arg_index,
   output logic                          last_of_frame
);
   import xcfr_pkg::*;

   logic [BYTE_W-1:0] body_mem [BUF_SIZE];

   logic              in_frame_ff, in_frame_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              star_seen_ff, star_seen_in;
   logic [FILL_W-1:0] star_pos_ff, star_pos_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] chk_ff, chk_in;
   logic              hex_end_ff, hex_end_in;
   logic [ARG_W-1:0]  arg_len_ff, arg_len_in;
   logic [ARG_W-1:0]  arg_k_ff, arg_k_in;
   logic [BYTE_W-1:0] addr_ff, cmd_ff;
   logic [BYTE_W-1:0] rd_data_ff;

   logic              is_start, is_end, is_star, full;
   logic              frame_ok, store_en;
   logic [4:0]        hex;
   logic [CMP_W-1:0]  blen_m2;
   logic [ADDR_W-1:0] rd_addr;

   assign is_start = (rx_byte == CH_START);
   assign is_end   = (rx_byte == CH_END);
   assign is_star  = (rx_byte == CH_STAR);
   assign full     = (fill_ff >= FILL_W'(BUF_SIZE - 1));
   assign hex      = hex_digit(rx_byte);
   assign frame_ok = star_seen_ff && (star_pos_ff >= FILL_W'(2)) && (xor_ff == chk_ff);
   assign blen_m2  = CMP_W'(star_pos_ff) - CMP_W'(2);
   assign store_en = cmd.take_byte && in_frame_ff && !is_start && !is_end && !full;
   assign rd_addr  = ADDR_W'(arg_k_ff) + ADDR_W'(2);

   assign stat.frame_done = in_frame_ff && is_end && !is_start && frame_ok;
   assign stat.arg_last   = (arg_len_ff == '0) ||
                            (ARG_W'(arg_k_ff) + ARG_W'(1) == arg_len_ff);

   always_comb begin
      in_frame_in  = in_frame_ff;
      fill_in      = fill_ff;
      star_seen_in = star_seen_ff;
      star_pos_in  = star_pos_ff;
      xor_in       = xor_ff;
      chk_in       = chk_ff;
      hex_end_in   = hex_end_ff;
      arg_len_in   = arg_len_ff;
      arg_k_in     = arg_k_ff;

      if (cmd.arg_next) begin
         arg_k_in = arg_k_ff + ARG_W'(1);
      end

      if (cmd.take_byte) begin
         if (is_start || (in_frame_ff && (is_end || full))) begin
            // '#' opens a frame; newline or overflow closes it
            in_frame_in  = is_start;
            fill_in      = '0;
            star_seen_in = 1'b0;
            star_pos_in  = '0;
            xor_in       = '0;
            chk_in       = '0;
            hex_end_in   = 1'b0;
            if (stat.frame_done) begin
               arg_k_in   = '0;
               arg_len_in = (blen_m2 > CMP_W'(ARG_SIZE - 1)) ? ARG_W'(ARG_SIZE - 1)
                                                             : ARG_W'(blen_m2);
            end
         end else if (in_frame_ff) begin
            fill_in = fill_ff + FILL_W'(1);
            if (!star_seen_ff) begin
               if (is_star) begin
                  star_seen_in = 1'b1;
                  star_pos_in  = fill_ff;
               end else begin
                  xor_in = xor_ff ^ rx_byte;
               end
            end else if (!hex_end_ff) begin
               if (hex[4]) begin
                  chk_in = {chk_ff[3:0], hex[3:0]};
               end else begin
                  hex_end_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         fill_ff      <= '0;
         star_seen_ff <= 1'b0;
         star_pos_ff  <= '0;
         xor_ff       <= '0;
         chk_ff       <= '0;
         hex_end_ff   <= 1'b0;
         arg_len_ff   <= '0;
         arg_k_ff     <= '0;
      end else begin
         in_frame_ff  <= in_frame_in;
         fill_ff      <= fill_in;
         star_seen_ff <= star_seen_in;
         star_pos_ff  <= star_pos_in;
         xor_ff       <= xor_in;
         chk_ff       <= chk_in;
         hex_end_ff   <= hex_end_in;
         arg_len_ff   <= arg_len_in;
         arg_k_ff     <= arg_k_in;
      end
   end

   // address and command bytes kept aside so the drain reads one port only
   always_ff @(posedge clock) begin
      if (store_en && fill_ff == FILL_W'(0)) begin
         addr_ff <= rx_byte;
      end
      if (store_en && fill_ff == FILL_W'(1)) begin
         cmd_ff <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         body_mem[ADDR_W'(fill_ff)] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.arg_read) begin
         rd_data_ff <= body_mem[rd_addr];
      end
   end

   assign has_arg_byte  = (arg_len_ff != '0);
   assign frame_addr    = addr_ff;
   assign frame_cmd     = cmd_ff;
   assign arg_byte      = has_arg_byte ? rd_data_ff : '0;
   assign arg_index     = has_arg_byte ? IDX_W'(arg_k_ff) : '0;
   assign last_of_frame = stat.arg_last;

endmodule

>>> rtl/xcfr_ctrl.sv
// ----------------------------------------------------------------------------
// xcfr_ctrl
// Sequencer: takes input beats, then drains an accepted frame's results.
// ----------------------------------------------------------------------------
`include "xor_checked_frame_receiver_assert.svh"

module xcfr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  xcfr_pkg::xcfr_stat_type  stat,
   output xcfr_pkg::xcfr_cmd_type   cmd
);
   import xcfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_take;

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = (state_ff == ST_SEND);
   assign rsp_take      = rsp_valid && rsp_ready;
   assign cmd.take_byte = req_valid && req_ready;
   assign cmd.arg_read  = (state_ff == ST_LOAD);
   assign cmd.arg_next  = rsp_take && !stat.arg_last;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take_byte && stat.frame_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_take) begin
               state_in = stat.arg_last ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `XCFR_ASSERT_NEXT(a_good_frame_loads, clock, reset, cmd.take_byte && stat.frame_done, cmd.arg_read)
   `XCFR_ASSERT_NEXT(a_load_then_send, clock, reset, cmd.arg_read, rsp_valid && !req_ready)
   `XCFR_ASSERT_NEXT(a_last_frees_input, clock, reset, rsp_take && stat.arg_last, req_ready)
   `XCFR_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid || cmd.arg_read, !req_ready)

endmodule

>>> rtl/xor_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Parses '#' body '*' hex '\n' frames and emits XOR-checked command results.
// ----------------------------------------------------------------------------
// Each input beat is one received byte. While idle the block takes a byte
// every cycle; a byte is fully absorbed in the cycle it is accepted. When a
// newline closes a frame whose body XOR matches the hex check value, input
// is held off while the frame is drained: one result beat per argument byte
// (or one beat for an empty argument), each read from the body store in the
// load state and then presented in the send state, plus any output stall.
// The number of result beats is the argument length clamped to ARG_SIZE-1,
// or one for an empty argument; the body store has a single read port.
// Rejected, overflowed and out-of-frame bytes never hold off input. The
// body store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   xcfr_req_if.sink    req_chan,
   xcfr_rsp_if.source  rsp_chan
);
   import xcfr_pkg::*;

   xcfr_cmd_type  cmd;
   xcfr_stat_type stat;

   // sequencer: handshakes and drain stepping
   xcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: frame tracking, checksum, body store, result fields
   xcfr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req_chan.rx_byte),
      .cmd           (cmd),
      .stat          (stat),
      .frame_addr    (rsp_chan.frame_addr),
      .frame_cmd     (rsp_chan.frame_cmd),
      .has_arg_byte  (rsp_chan.has_arg_byte),
      .arg_byte      (rsp_chan.arg_byte),
      .arg_index     (rsp_chan.arg_index),
      .last_of_frame (rsp_chan.last_of_frame)
   );

endmodule

>>> tb/sv/xcfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfr_frame_checker
// Watches both channels of the frame receiver, rebuilds every frame from the
// accepted input beats and checks each result beat against the oldest one
// still due.
// ----------------------------------------------------------------------------
module xcfr_frame_checker
   import xcfr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   xcfr_req_if  req_mon,
   xcfr_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] cmd;
      logic              has_arg;
      logic [BYTE_W-1:0] arg;
      logic [IDX_W-1:0]  idx;
      logic              last;
   } frame_result_type;

   frame_result_type  due_q[$];
   frame_result_type  head;

   // frame assembly state
   logic              open_frame;
   logic [6:0]        fill;
   logic [BYTE_W-1:0] store [BUF_SIZE];
   logic              star_found;
   logic [6:0]        body_len;
   logic [BYTE_W-1:0] body_xor;
   logic [BYTE_W-1:0] check_sum;
   logic              hex_over;
   int                errors = 0;

   function automatic int hex_value(input logic [BYTE_W-1:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 'h30;
      if (c >= "A" && c <= "F") return int'(c) - 'h41 + 10;
      if (c >= "a" && c <= "f") return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   task automatic restart_frame();
      fill       = '0;
      star_found = 1'b0;
      body_len   = '0;
      body_xor   = '0;
      check_sum  = '0;
      hex_over   = 1'b0;
   endtask

   task automatic absorb_byte(input logic [BYTE_W-1:0] c);
      int               arg_len;
      int               d;
      frame_result_type r;
      if (c == CH_START) begin
         open_frame = 1'b1;
         restart_frame();
      end else if (open_frame) begin
         if (c == CH_END) begin
            open_frame = 1'b0;
            if (star_found && body_len >= 2 && body_xor == check_sum) begin
               arg_len = int'(body_len) - 2;
               if (arg_len > ARG_SIZE - 1) arg_len = ARG_SIZE - 1;
               r.addr = store[0];
               r.cmd  = store[1];
               if (arg_len == 0) begin
                  r.has_arg = 1'b0;
                  r.arg     = '0;
                  r.idx     = '0;
                  r.last    = 1'b1;
                  due_q.push_back(r);
               end else begin
                  for (int k = 0; k < arg_len; k++) begin
                     r.has_arg = 1'b1;
                     r.arg     = store[k + 2];
                     r.idx     = IDX_W'(k);
                     r.last    = (k == arg_len - 1);
                     due_q.push_back(r);
                  end
               end
            end
            restart_frame();
         end else if (fill >= BUF_SIZE - 1) begin
            // store full: frame abandoned, byte lost
            open_frame = 1'b0;
            restart_frame();
         end else begin
            store[fill[$clog2(BUF_SIZE)-1:0]] = c;
            if (!star_found) begin
               if (c == CH_STAR) begin
                  star_found = 1'b1;
                  body_len   = fill;
               end else begin
                  body_xor ^= c;
               end
            end else if (!hex_over) begin
               d = hex_value(c);
               if (d < 0) hex_over = 1'b1;
               else check_sum = BYTE_W'(check_sum * 16 + d);
            end
            fill++;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         open_frame = 1'b0;
         restart_frame();
         due_q.delete();
      end else begin
         // results first: a beat can never come from the byte taken this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_q.size() == 0) begin
               $display("%0t: result beat expected none, actual addr %h cmd %h arg %h idx %0d",
                        $time, rsp_mon.frame_addr, rsp_mon.frame_cmd, rsp_mon.arg_byte,
                        rsp_mon.arg_index);
               errors++;
            end else begin
               head = due_q.pop_front();
               check_field("frame_addr", head.addr, rsp_mon.frame_addr);
               check_field("frame_cmd", head.cmd, rsp_mon.frame_cmd);
               check_field("has_arg_byte", 8'(head.has_arg), 8'(rsp_mon.has_arg_byte));
               check_field("arg_byte", head.arg, rsp_mon.arg_byte);
               check_field("arg_index", 8'(head.idx), 8'(rsp_mon.arg_index));
               check_field("last_of_frame", 8'(head.last), 8'(rsp_mon.last_of_frame));
            end
         end
         if (req_mon.valid && req_mon.ready) absorb_byte(req_mon.rx_byte);
      end
      fail_count  <= errors;
      outstanding <= due_q.size();
   end

endmodule

>>> tb/sv/tb_xor_checked_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_checked_frame_receiver
// Feeds the frame receiver a byte stream of directed and random frames, with
// random gaps on the input and random stalls on the result channel; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_xor_checked_frame_receiver;
   import xcfr_pkg::*;

   localparam int ITEMS = 300;     // random bytes to send
   localparam int LIMIT = 400000;  // cycle budget for the whole run
   localparam int TAIL  = 200;     // quiet cycles after the last result

   // How the check field after '*' is written.
   typedef enum {
      CHK_PAIR,     // two hex digits
      CHK_SHORT,    // leading zero dropped
      CHK_LONG,     // extra leading digits, value wraps to the low byte
      CHK_BAD,      // two digits of a wrong value
      CHK_EMPTY,    // '*' with no digits: value 0
      CHK_OMITTED   // no '*' at all
   } check_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xcfr_req_if req_if ();
   xcfr_rsp_if rsp_if ();

   int fail_count;
   int outstanding;
   int cycles     = 0;
   int sent_count = 0;
   bit send_calm  = 1'b0;   // sender phase with no gaps

   // body lengths for the size extremes: 33 fills ARG_SIZE-1 exactly, 34 is
   // clamped, 60 plus '*' and two digits fills the store, 61 overflows it
   int len_list[4] = '{33, 34, 60, 61};

   xor_checked_frame_receiver dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   xcfr_frame_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop: a hung handshake or a result that never comes ends here.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 10) return 8'h30 + n;
      return (upper ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   // Any byte that can sit in a body without ending it early.
   function automatic logic [7:0] rand_body_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_START || b == CH_END || b == CH_STAR);
      return b;
   endfunction

   // Result side: stall pattern of its own, with calm phases where ready
   // stays high so frames drain at full rate.
   int  stall_left = 0;
   int  phase_left = 0;
   bit  drain_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(50, 300);
            drain_calm = ($urandom_range(0, 3) == 0);
         end
         phase_left--;
         if (stall_left == 0 && !drain_calm) stall_left = pick_gap(1'b0);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // One beat on the input. valid stays up across back-to-back beats and
   // is only dropped when a gap comes first.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
   endtask

   // Whole frame: '#', body, check field in the given style, optional junk
   // after the digits, newline.
   task automatic send_frame(input logic [7:0] body[$], input check_style_type style,
                             input bit upper, input int trail);
      logic [7:0] sum;
      logic [7:0] bad;
      logic [7:0] junk;
      logic [7:0] line[$];
      sum = '0;
      line.push_back(CH_START);
      foreach (body[i]) begin
         sum ^= body[i];
         line.push_back(body[i]);
      end
      if (style != CHK_OMITTED) line.push_back(CH_STAR);
      unique case (style)
         CHK_PAIR: begin
            line.push_back(hex_char(sum[7:4], upper));
            line.push_back(hex_char(sum[3:0], upper));
         end
         CHK_SHORT: begin
            if (sum[7:4] != 0) line.push_back(hex_char(sum[7:4], upper));
            line.push_back(hex_char(sum[3:0], upper));
         end
         CHK_LONG: begin
            // leading digits shift out of the low byte; mixed case
            repeat ($urandom_range(1, 4))
               line.push_back(hex_char(4'($urandom_range(0, 15)),
                                       1'($urandom_range(0, 1))));
            line.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
            line.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
         end
         CHK_BAD: begin
            bad = sum ^ 8'($urandom_range(1, 255));
            line.push_back(hex_char(bad[7:4], upper));
            line.push_back(hex_char(bad[3:0], upper));
         end
         default: ;
      endcase
      // junk after the digits; the first byte must not be a hex digit or it
      // would extend the check value
      for (int i = 0; i < trail; i++) begin
         do junk = 8'($urandom_range(0, 255));
         while (junk == CH_START || junk == CH_END ||
                (i == 0 && ((junk >= "0" && junk <= "9") || (junk >= "A" && junk <= "F") ||
                            (junk >= "a" && junk <= "f"))));
         line.push_back(junk);
      end
      line.push_back(CH_END);
      foreach (line[i]) send_byte(line[i]);
   endtask

   initial begin
      logic [7:0]      body[$];
      check_style_type style;
      int              r;
      int              len;
      int              trail;
      int              frames;
      int              random_base;

      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // outside a frame everything but '#' is dropped, newline included
      send_byte(CH_END);
      send_byte(8'hFF);
      send_byte(CH_STAR);
      // two-byte body: empty argument, addr/cmd at both extremes
      send_frame('{8'h00, 8'hFF}, CHK_PAIR, 1'b1, 0);
      // argument with extreme and zero bytes, lower-case digits, junk after
      send_frame('{8'hFF, 8'h00, 8'h00, 8'hFF}, CHK_PAIR, 1'b0, 2);
      // body XOR is zero, so a bare '*' checks out
      send_frame('{8'h5A, 8'h3C, 8'h66}, CHK_EMPTY, 1'b1, 0);
      // long hex string wraps to its low byte
      send_frame('{8'h12, 8'h34, 8'h56}, CHK_LONG, 1'b1, 0);
      // checksum mismatch, missing '*', one-byte body: all dropped
      send_frame('{8'h01, 8'h02, 8'h03}, CHK_BAD, 1'b1, 0);
      send_frame('{8'h01, 8'h02}, CHK_OMITTED, 1'b1, 0);
      send_frame('{8'h41}, CHK_PAIR, 1'b1, 0);
      // '#' mid-frame restarts assembly
      send_byte(CH_START);
      send_byte(8'h41);
      send_frame('{8'h10, 8'h20, 8'h30}, CHK_SHORT, 1'b0, 0);

      // ---- random ----
      random_base = sent_count;
      frames      = 0;

      // the big sizes first, once each: argument exactly at the clamp, one
      // past it, store filled to the last slot, and one byte over
      foreach (len_list[i]) begin
         body.delete();
         repeat (len_list[i]) body.push_back(rand_body_byte());
         send_frame(body, CHK_PAIR, 1'($urandom_range(0, 1)), 0);
      end

      while (sent_count - random_base < ITEMS) begin
         // sender switches between gappy and back-to-back stretches
         if (frames % 12 == 0) send_calm = ($urandom_range(0, 3) == 0);
         frames++;

         body.delete();
         r = $urandom_range(0, 99);
         if (r < 5)       len = $urandom_range(0, 1);
         else if (r < 94) len = $urandom_range(2, 9);
         else             len = $urandom_range(30, 62);
         repeat (len) body.push_back(rand_body_byte());
         trail = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);

         r = $urandom_range(0, 99);
         if (r < 86) begin
            if (r < 40)      style = CHK_PAIR;
            else if (r < 55) style = CHK_SHORT;
            else if (r < 70) style = CHK_LONG;
            else if (r < 78) style = CHK_BAD;
            else if (r < 83) style = CHK_OMITTED;
            else             style = CHK_EMPTY;
            send_frame(body, style, 1'($urandom_range(0, 1)), trail);
         end else if (r < 93) begin
            // broken frame: no newline, the next '#' cuts it off
            send_byte(CH_START);
            foreach (body[i]) send_byte(body[i]);
         end else begin
            // line noise, any byte value
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
      end

      // ---- drain ----
      req_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/xcfr_pkg.sv
rtl/xcfr_req_if.sv
rtl/xcfr_rsp_if.sv
rtl/xcfr_dp.sv
rtl/xcfr_ctrl.sv
rtl/xor_checked_frame_receiver.sv
tb/sv/xcfr_frame_checker.sv
tb/sv/tb_xor_checked_frame_receiver.sv
